[rtl/bkvb_pkg.sv]
// Shared constants for the B-spline knot vector builder.
// No dependencies; used by bspline_knot_vector_builder.
package bkvb_pkg;

    localparam int MAX_SAMPLES = 48;
    localparam int SAMPLE_W    = 32;
    localparam int KNOT_W      = 34;
    localparam int BASIS_LIMIT = 48;
    localparam int IDX_W       = 6;
    localparam int ACC_W       = SAMPLE_W + 4;
    localparam int DVD_W       = 42;
    localparam int DVS_W       = 8;
    localparam int ADDR_W      = 4;
    localparam int MAX_INTERIOR = 10;
    localparam int WIDEN_DIV   = 10;
    localparam int WIDEN_BIAS  = 5;
    localparam logic [31:0] WIDEN_RECIP = 32'hCCCC_CCCD;
    localparam int WIDEN_SHIFT = 34;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_FEW  = 2'd1;
    localparam logic [1:0] ERR_OVF  = 2'd2;

    localparam logic [1:0] MODE_AVG     = 2'd0;
    localparam logic [1:0] MODE_CLAMPED = 2'd1;
    localparam logic [1:0] MODE_UNIFORM = 2'd2;
    localparam logic [1:0] MODE_WIDENED = 2'd3;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_DEGREE = 2'd1;
    localparam logic [1:0] REG_BASIS  = 2'd2;

endpackage

[rtl/bspline_knot_vector_builder.sv]
// Top level of the B-spline knot vector builder: sorted sample store in one
// synchronous memory, knot sequencer, shared radix-2 divider, APB registers.
// Depends on bkvb_pkg.
//
//  channel | signals                                    | dir
//  input   | in_valid, in_stall, sample_value, last_sample | in (stall out)
//  output  | out_valid, out_stall, knot_value, error_code, last_knot | out
//  config  | psel, penable, pwrite, paddr, pwdata, prdata, pready  | APB
//
// An insert reads and compares each stored entry below the new value, then
// reads and writes each entry shifted up; the next beat waits until it ends,
// as the single memory port sets it. A build reads each averaging window one
// entry at a time and runs the shared divider per average or uniform knot; the
// widened ends take one multiply. Reset is asynchronous and clears control
// state; the store needs no clearing. An output stall holds the sequencer.
module bspline_knot_vector_builder (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [bkvb_pkg::SAMPLE_W-1:0] sample_value,
    input  logic                               last_sample,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [bkvb_pkg::KNOT_W-1:0] knot_value,
    output logic [1:0]                         error_code,
    output logic                               last_knot,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bkvb_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int IW = bkvb_pkg::IDX_W;
    localparam int SW = bkvb_pkg::SAMPLE_W;
    localparam int KW = bkvb_pkg::KNOT_W;
    localparam int AW = bkvb_pkg::ACC_W;
    localparam int DW = bkvb_pkg::DVD_W;
    localparam int VW = bkvb_pkg::DVS_W;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_INSERT, S_SHIFT_RD, S_SHIFT_WR,
        S_B_START, S_B_RD_LAST, S_B_PLAN, S_K_NEXT, S_W_RD, S_W_ACC,
        S_W_LOAD, S_DIV, S_DIV_DONE, S_EMIT, S_ERR
    } state_t;

    typedef enum logic [1:0] {
        DK_AVG, DK_UNIF, DK_WIDEN
    } div_kind_t;

    state_t    state_reg;
    div_kind_t kind_reg;

    logic [1:0]    mode_reg;
    logic [2:0]    degree_reg;
    logic [5:0]    basis_reg;

    logic [IW-1:0] count_reg;
    logic          ovf_reg;
    logic [SW-1:0] val_reg;
    logic          last_reg;
    logic [IW-1:0] pos_reg;
    logic [IW-1:0] idx_reg;

    logic signed [SW-1:0] first_reg;
    logic signed [SW-1:0] lastv_reg;
    logic [3:0]    c1_reg;
    logic [IW-1:0] c2_reg;
    logic [IW-1:0] tot_reg;
    logic [IW-1:0] m_reg;
    logic signed [KW-1:0] start_reg;
    logic [KW-1:0] span_reg;
    logic [IW-1:0] k_reg;
    logic [IW-1:0] widx_reg;
    logic [3:0]    j_reg;
    logic signed [AW-1:0] acc_reg;
    logic [DW-1:0] dvd_reg;
    logic [VW-1:0] dvs_reg;
    logic [VW-1:0] rem_reg;
    logic [IW-1:0] dcnt_reg;
    logic          neg_reg;
    logic [1:0]    err_reg;
    logic signed [KW-1:0] knot_reg;

    logic          out_valid_reg;
    logic signed [KW-1:0] out_knot_reg;
    logic [1:0]    out_err_reg;
    logic          out_last_reg;

    logic [SW-1:0] mem [bkvb_pkg::MAX_SAMPLES];
    logic [SW-1:0] rd_data;
    logic [IW-1:0] mem_ra;
    logic [IW-1:0] mem_wa;
    logic [SW-1:0] mem_wd;
    logic          mem_we;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data <= mem[mem_ra];
    end

    always_comb
    begin
        mem_ra = pos_reg;
        mem_wa = idx_reg;
        mem_wd = rd_data;
        mem_we = 1'b0;
        case (state_reg)
            S_SHIFT_RD:
            begin
                mem_ra = idx_reg - 1'b1;
                mem_wa = pos_reg;
                mem_wd = val_reg;
                mem_we = (idx_reg == pos_reg);
            end
            S_SHIFT_WR:  mem_we = 1'b1;
            S_B_START:   mem_ra = '0;
            S_B_RD_LAST: mem_ra = count_reg - 1'b1;
            S_W_RD:      mem_ra = widx_reg + IW'(j_reg);
            default:     mem_ra = pos_reg;
        endcase
    end

    // plan values
    logic [IW-1:0] nb;
    logic [IW-1:0] p6;
    logic [IW-1:0] m_clamp;
    logic [IW-1:0] ni_raw;
    logic [IW-1:0] ni;
    logic [KW-1:0] span_now;
    logic [IW-1:0] rel;
    logic [IW-1:0] m_dec;
    logic [DW-1:0] prod;
    logic [3:0]    w;
    logic signed [AW+1:0] num;
    logic [DW-1:0] num_mag;
    logic [VW:0]   rem_sh;
    logic          geq;
    logic [VW:0]   rem_sub;
    logic          slot_free;
    logic          out_load;
    logic [63:0]   tenth_prod;
    logic [KW-1:0] widen_e;

    always_comb
    begin
        nb       = (basis_reg > IW'(bkvb_pkg::BASIS_LIMIT))
                   ? IW'(bkvb_pkg::BASIS_LIMIT) : basis_reg;
        p6       = IW'(degree_reg);
        m_clamp  = (nb != '0) ? nb : count_reg;
        ni_raw   = m_clamp - p6 - 1'b1;
        ni       = (ni_raw > IW'(bkvb_pkg::MAX_INTERIOR))
                   ? IW'(bkvb_pkg::MAX_INTERIOR) : ni_raw;
        span_now = KW'(signed'(rd_data)) - KW'(first_reg);
        rel      = k_reg - IW'(c1_reg);
        m_dec    = m_reg - 1'b1;
        prod     = DW'(rel) * DW'(span_reg);
        w        = 4'(degree_reg) + 4'd2;
        num      = ((AW+2)'(acc_reg) <<< 1) + (AW+2)'(w);
        num_mag  = num[AW+1] ? DW'(-num + (AW+2)'({w, 1'b0}) - 1)
                             : DW'(num);
        rem_sh   = {rem_reg, dvd_reg[DW-1]};
        geq      = (rem_sh >= {1'b0, dvs_reg});
        rem_sub  = rem_sh - {1'b0, dvs_reg};
        slot_free = !out_valid_reg || !out_stall;
        out_load = slot_free && (state_reg == S_EMIT || state_reg == S_ERR);
        // tenth of (span + 5): halve, then multiply by the reciprocal of 5
        tenth_prod = 64'(dvd_reg[SW:1]) * 64'(bkvb_pkg::WIDEN_RECIP);
        widen_e  = KW'(tenth_prod[63:bkvb_pkg::WIDEN_SHIFT]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= DK_AVG;
            mode_reg      <= bkvb_pkg::MODE_AVG;
            degree_reg    <= 3'd3;
            basis_reg     <= 6'd10;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                case (paddr[3:2])
                    bkvb_pkg::REG_MODE:   mode_reg   <= pwdata[1:0];
                    bkvb_pkg::REG_DEGREE: degree_reg <= pwdata[2:0];
                    bkvb_pkg::REG_BASIS:  basis_reg  <= pwdata[5:0];
                    default:              ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        val_reg   <= sample_value;
                        last_reg  <= last_sample;
                        pos_reg   <= '0;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= (pos_reg == count_reg) ? S_INSERT : S_SCAN_CMP;
                end
                S_SCAN_CMP:
                begin
                    if (signed'(rd_data) < signed'(val_reg))
                    begin
                        pos_reg   <= pos_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                    else if (rd_data == val_reg)
                    begin
                        state_reg <= last_reg ? S_B_START : S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_INSERT;
                    end
                end
                S_INSERT:
                begin
                    if (count_reg >= IW'(bkvb_pkg::MAX_SAMPLES))
                    begin
                        ovf_reg   <= 1'b1;
                        state_reg <= last_reg ? S_B_START : S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= count_reg;
                        state_reg <= S_SHIFT_RD;
                    end
                end
                S_SHIFT_RD:
                begin
                    if (idx_reg == pos_reg)
                    begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= last_reg ? S_B_START : S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR:
                begin
                    idx_reg   <= idx_reg - 1'b1;
                    state_reg <= S_SHIFT_RD;
                end
                S_B_START:
                begin
                    if (ovf_reg)
                    begin
                        err_reg   <= bkvb_pkg::ERR_OVF;
                        state_reg <= S_ERR;
                    end
                    else if (count_reg == '0)
                    begin
                        err_reg   <= bkvb_pkg::ERR_FEW;
                        state_reg <= S_ERR;
                    end
                    else
                    begin
                        state_reg <= S_B_RD_LAST;
                    end
                end
                S_B_RD_LAST:
                begin
                    first_reg <= rd_data;
                    state_reg <= S_B_PLAN;
                end
                S_B_PLAN:
                begin
                    lastv_reg <= rd_data;
                    start_reg <= KW'(first_reg);
                    span_reg  <= span_now;
                    k_reg     <= '0;
                    err_reg   <= bkvb_pkg::ERR_FEW;
                    case (mode_reg)
                        bkvb_pkg::MODE_AVG:
                        begin
                            c1_reg  <= 4'(degree_reg) + 4'd1;
                            c2_reg  <= count_reg - p6 - 1'b1;
                            tot_reg <= count_reg + p6 + 1'b1;
                            state_reg <= (count_reg < p6 + 1'b1) ? S_ERR : S_K_NEXT;
                        end
                        bkvb_pkg::MODE_CLAMPED:
                        begin
                            c1_reg  <= 4'(degree_reg);
                            c2_reg  <= ni;
                            m_reg   <= ni;
                            tot_reg <= ni + (p6 <<< 1);
                            if (m_clamp < p6 + 1'b1 || (ni == '0 && p6 == '0))
                            begin
                                state_reg <= S_ERR;
                            end
                            else
                            begin
                                state_reg <= S_K_NEXT;
                            end
                        end
                        bkvb_pkg::MODE_UNIFORM:
                        begin
                            c1_reg    <= '0;
                            c2_reg    <= nb + p6 + 1'b1;
                            m_reg     <= nb + p6 + 1'b1;
                            tot_reg   <= nb + p6 + 1'b1;
                            state_reg <= S_K_NEXT;
                        end
                        default:
                        begin
                            c1_reg    <= '0;
                            c2_reg    <= nb + p6 + 1'b1;
                            m_reg     <= nb + p6 + 1'b1;
                            tot_reg   <= nb + p6 + 1'b1;
                            dvd_reg   <= DW'(span_now) + DW'(bkvb_pkg::WIDEN_BIAS);
                            kind_reg  <= DK_WIDEN;
                            state_reg <= S_DIV_DONE;
                        end
                    endcase
                end
                S_K_NEXT:
                begin
                    if (k_reg == tot_reg)
                    begin
                        count_reg <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                    else if (k_reg < IW'(c1_reg))
                    begin
                        knot_reg  <= KW'(first_reg);
                        state_reg <= S_EMIT;
                    end
                    else if (k_reg < IW'(c1_reg) + c2_reg)
                    begin
                        if (mode_reg == bkvb_pkg::MODE_AVG)
                        begin
                            acc_reg   <= '0;
                            j_reg     <= '0;
                            widx_reg  <= rel;
                            state_reg <= S_W_RD;
                        end
                        else if (m_reg <= IW'(1))
                        begin
                            knot_reg  <= start_reg;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            dvd_reg   <= (prod <<< 1) + DW'(m_dec);
                            dvs_reg   <= VW'({m_dec, 1'b0});
                            rem_reg   <= '0;
                            dcnt_reg  <= '0;
                            kind_reg  <= DK_UNIF;
                            state_reg <= S_DIV;
                        end
                    end
                    else
                    begin
                        knot_reg  <= KW'(lastv_reg);
                        state_reg <= S_EMIT;
                    end
                end
                S_W_RD:
                begin
                    state_reg <= S_W_ACC;
                end
                S_W_ACC:
                begin
                    acc_reg <= acc_reg + AW'(signed'(rd_data));
                    if (j_reg == 4'(degree_reg) + 4'd1)
                    begin
                        state_reg <= S_W_LOAD;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_W_RD;
                    end
                end
                S_W_LOAD:
                begin
                    dvd_reg   <= num_mag;
                    neg_reg   <= num[AW+1];
                    dvs_reg   <= VW'({w, 1'b0});
                    rem_reg   <= '0;
                    dcnt_reg  <= '0;
                    kind_reg  <= DK_AVG;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= geq ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
                    dvd_reg  <= {dvd_reg[DW-2:0], geq};
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == IW'(DW - 1))
                    begin
                        state_reg <= S_DIV_DONE;
                    end
                end
                S_DIV_DONE:
                begin
                    case (kind_reg)
                        DK_AVG:
                        begin
                            knot_reg  <= neg_reg ? -KW'(dvd_reg) : KW'(dvd_reg);
                            state_reg <= S_EMIT;
                        end
                        DK_UNIF:
                        begin
                            knot_reg  <= start_reg + KW'(dvd_reg);
                            state_reg <= S_EMIT;
                        end
                        default:
                        begin
                            start_reg <= start_reg - widen_e;
                            span_reg  <= span_reg + (widen_e <<< 1);
                            state_reg <= S_K_NEXT;
                        end
                    endcase
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_knot_reg  <= knot_reg;
                        out_err_reg   <= bkvb_pkg::ERR_NONE;
                        out_last_reg  <= (k_reg + 1'b1 == tot_reg);
                        k_reg         <= k_reg + 1'b1;
                        state_reg     <= S_K_NEXT;
                    end
                end
                S_ERR:
                begin
                    if (slot_free)
                    begin
                        out_knot_reg  <= '0;
                        out_err_reg   <= err_reg;
                        out_last_reg  <= 1'b1;
                        count_reg     <= '0;
                        ovf_reg       <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            bkvb_pkg::REG_MODE:   prdata = {30'd0, mode_reg};
            bkvb_pkg::REG_DEGREE: prdata = {29'd0, degree_reg};
            bkvb_pkg::REG_BASIS:  prdata = {26'd0, basis_reg};
            default:              prdata = '0;
        endcase
    end

    assign pready     = 1'b1;
    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign knot_value = out_knot_reg;
    assign error_code = out_err_reg;
    assign last_knot  = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= IW'(bkvb_pkg::MAX_SAMPLES))
        else $error("store count beyond depth");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == IW'(bkvb_pkg::MAX_SAMPLES)))
        else $error("overflow flagged with room left");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("store written while idle");

    a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> (state_reg == S_SCAN_RD))
        else $error("accepted beat did not start a scan");

endmodule

[dv/tb_top.sv]
// Self-checking bench for bspline_knot_vector_builder: directed table, then random data sets.
// Knots are predicted in-bench from the sorted sample store; depends on bkvb_pkg and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 5000000;
    localparam int RAND_ITEMS  = 110;
    localparam int SETTLE      = 300;

    typedef struct packed {
        logic [bkvb_pkg::KNOT_W-1:0] knot;
        logic [1:0]        err;
        logic              lst;
    } knot_t;

    typedef struct {
        bit          cfg;
        logic [1:0]  mode;
        logic [2:0]  deg;
        logic [5:0]  basis;
        logic [31:0] sample;
        bit          lst;
        bit          typed;
        longint      t_knot;
        logic [1:0]  t_err;
    } row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [bkvb_pkg::SAMPLE_W-1:0] sample_value = '0;
    logic                       last_sample = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [bkvb_pkg::KNOT_W-1:0]   knot_value;
    logic [1:0]                 error_code;
    logic                       last_knot;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [bkvb_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]                pwdata = '0;
    logic [31:0]                prdata;
    logic                       pready;

    bspline_knot_vector_builder dut (.*);

    longint     store_vals[bkvb_pkg::MAX_SAMPLES];
    int         store_cnt = 0;
    bit         store_ovf = 1'b0;
    logic [1:0] cur_mode = bkvb_pkg::MODE_AVG;
    int         cur_deg = 3;
    int         cur_basis = 10;

    knot_t knot_q[$];
    int    fails = 0;
    int    knots_seen = 0;
    int    sets_sent = 0;
    int    samples_sent = 0;
    int    cycles = 0;
    bit    offering = 1'b0;
    int    burst_left = 4;
    bit    hold_req = 1'b0;
    int    hold_cnt = 0;

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic void store_sample(logic [31:0] raw);
        longint v;
        int pos;
        v = longint'(signed'(raw));
        pos = 0;
        while (pos < store_cnt && store_vals[pos] < v)
            pos++;
        if (pos < store_cnt && store_vals[pos] == v)
            return;
        if (store_cnt >= bkvb_pkg::MAX_SAMPLES)
        begin
            store_ovf = 1'b1;
            return;
        end
        for (int i = store_cnt; i > pos; i--)
            store_vals[i] = store_vals[i-1];
        store_vals[pos] = v;
        store_cnt++;
    endfunction

    function automatic longint spread(longint start, longint span, int i, int m);
        longint d;
        if (m <= 1)
            return start;
        d = m - 1;
        return start + (2 * longint'(i) * span + d) / (2 * d);
    endfunction

    function automatic void enqueue_knot(knot_t k);
        knot_q.insert(knot_q.size(), k);
    endfunction

    function automatic void push_error(logic [1:0] code);
        knot_t k;
        k.knot = '0;
        k.err = code;
        k.lst = 1'b1;
        enqueue_knot(k);
    endfunction

    function automatic void predict_knots();
        longint kv[$];
        longint span, start, e, sum, w, q;
        int n, p, nb, m, ni, nk;
        knot_t k;
        n = store_cnt;
        p = cur_deg;
        nb = (cur_basis > bkvb_pkg::BASIS_LIMIT) ? bkvb_pkg::BASIS_LIMIT : cur_basis;
        if (store_ovf)
        begin
            push_error(bkvb_pkg::ERR_OVF);
            return;
        end
        if (n == 0)
        begin
            push_error(bkvb_pkg::ERR_FEW);
            return;
        end
        span = store_vals[n-1] - store_vals[0];
        if (cur_mode == bkvb_pkg::MODE_AVG)
        begin
            if (n < p + 1)
            begin
                push_error(bkvb_pkg::ERR_FEW);
                return;
            end
            for (int i = 0; i <= p; i++)
                kv.insert(kv.size(), store_vals[0]);
            for (int i = 0; i + p + 1 < n; i++)
            begin
                sum = 0;
                w = p + 2;
                for (int j = 0; j < p + 2; j++)
                    sum += store_vals[i+j];
                q = (2 * sum + w) / (2 * w);
                if (((2 * sum + w) % (2 * w)) != 0 && (2 * sum + w) < 0)
                    q--;
                kv.insert(kv.size(), q);
            end
            for (int i = 0; i <= p; i++)
                kv.insert(kv.size(), store_vals[n-1]);
        end
        else if (cur_mode == bkvb_pkg::MODE_CLAMPED)
        begin
            m = (nb > 0) ? nb : n;
            if (m < p + 1)
            begin
                push_error(bkvb_pkg::ERR_FEW);
                return;
            end
            ni = m - p - 1;
            if (ni > bkvb_pkg::MAX_INTERIOR)
                ni = bkvb_pkg::MAX_INTERIOR;
            if (ni + 2 * p == 0)
            begin
                push_error(bkvb_pkg::ERR_FEW);
                return;
            end
            for (int i = 0; i < p; i++)
                kv.insert(kv.size(), store_vals[0]);
            for (int i = 0; i < ni; i++)
                kv.insert(kv.size(), spread(store_vals[0], span, i, ni));
            for (int i = 0; i < p; i++)
                kv.insert(kv.size(), store_vals[n-1]);
        end
        else
        begin
            nk = nb + p + 1;
            start = store_vals[0];
            if (cur_mode == bkvb_pkg::MODE_WIDENED)
            begin
                e = (span + bkvb_pkg::WIDEN_BIAS) / bkvb_pkg::WIDEN_DIV;
                start -= e;
                span += 2 * e;
            end
            for (int i = 0; i < nk; i++)
                kv.insert(kv.size(), spread(start, span, i, nk));
        end
        foreach (kv[i])
        begin
            k.knot = kv[i][bkvb_pkg::KNOT_W-1:0];
            k.err = bkvb_pkg::ERR_NONE;
            k.lst = (i == kv.size() - 1);
            enqueue_knot(k);
        end
    endfunction

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= bkvb_pkg::ADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        while (knot_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic setup_regs(logic [1:0] mode, logic [2:0] deg, logic [5:0] basis);
        drain();
        apb_write(bkvb_pkg::REG_MODE, 32'(mode));
        apb_write(bkvb_pkg::REG_DEGREE, 32'(deg));
        apb_write(bkvb_pkg::REG_BASIS, 32'(basis));
        cur_mode = mode;
        cur_deg = int'(deg);
        cur_basis = int'(basis);
    endtask

    // hold the beat until accepted, then update the store; typed rows bypass prediction
    task automatic send_sample(logic [31:0] v, bit lst, bit typed, longint t_knot,
                               logic [1:0] t_err);
        knot_t k;
        in_valid <= 1'b1;
        sample_value <= v;
        last_sample <= lst;
        offering = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        samples_sent++;
        store_sample(v);
        if (lst)
        begin
            sets_sent++;
            if (typed)
            begin
                k.knot = t_knot[bkvb_pkg::KNOT_W-1:0];
                k.err = t_err;
                k.lst = 1'b1;
                enqueue_knot(k);
            end
            else
                predict_knots();
            store_cnt = 0;
            store_ovf = 1'b0;
        end
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        end
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'(signed'($urandom_range(0, 16)) - 8) <<< 16;
            2: return 32'(signed'($urandom_range(0, 2000)) - 1000);
            default: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
        endcase
    endfunction

    row_t plan[] = '{
        '{1, bkvb_pkg::MODE_AVG,     3, 10, 32'h0001_0000, 1, 1, 0, bkvb_pkg::ERR_FEW},
        '{1, bkvb_pkg::MODE_AVG,     0, 10, 32'h8000_0000, 0, 0, 0, bkvb_pkg::ERR_NONE},
        '{0, bkvb_pkg::MODE_AVG,     0, 10, 32'h7fff_ffff, 0, 0, 0, bkvb_pkg::ERR_NONE},
        '{0, bkvb_pkg::MODE_AVG,     0, 10, 32'h0000_0000, 1, 0, 0, bkvb_pkg::ERR_NONE},
        '{1, bkvb_pkg::MODE_UNIFORM, 0, 0,  32'h0001_2345, 0, 0, 0, bkvb_pkg::ERR_NONE},
        '{0, bkvb_pkg::MODE_UNIFORM, 0, 0,  32'h0001_2345, 1, 1, 'h12345,
          bkvb_pkg::ERR_NONE},
        '{1, bkvb_pkg::MODE_CLAMPED, 0, 1,  32'd5,         0, 0, 0, bkvb_pkg::ERR_NONE},
        '{0, bkvb_pkg::MODE_CLAMPED, 0, 1,  32'd9,         1, 1, 0, bkvb_pkg::ERR_FEW},
        '{1, bkvb_pkg::MODE_WIDENED, 7, 48, 32'h8000_0000, 0, 0, 0, bkvb_pkg::ERR_NONE},
        '{0, bkvb_pkg::MODE_WIDENED, 7, 48, 32'h7fff_ffff, 0, 0, 0, bkvb_pkg::ERR_NONE},
        '{0, bkvb_pkg::MODE_WIDENED, 7, 48, 32'h0000_0001, 1, 0, 0, bkvb_pkg::ERR_NONE},
        '{1, bkvb_pkg::MODE_CLAMPED, 2, 0,  32'd100,       0, 0, 0, bkvb_pkg::ERR_NONE},
        '{0, bkvb_pkg::MODE_CLAMPED, 2, 0,  -32'sd300,     0, 0, 0, bkvb_pkg::ERR_NONE},
        '{0, bkvb_pkg::MODE_CLAMPED, 2, 0,  32'd7000,      0, 0, 0, bkvb_pkg::ERR_NONE},
        '{0, bkvb_pkg::MODE_CLAMPED, 2, 0,  32'd50,        1, 0, 0, bkvb_pkg::ERR_NONE},
        '{1, bkvb_pkg::MODE_UNIFORM, 7, 63, -32'sd5,       0, 0, 0, bkvb_pkg::ERR_NONE},
        '{0, bkvb_pkg::MODE_UNIFORM, 7, 63, 32'h0003_0000, 1, 0, 0, bkvb_pkg::ERR_NONE},
        '{1, bkvb_pkg::MODE_CLAMPED, 7, 48, 32'd10,        0, 0, 0, bkvb_pkg::ERR_NONE},
        '{0, bkvb_pkg::MODE_CLAMPED, 7, 48, 32'd20,        0, 0, 0, bkvb_pkg::ERR_NONE},
        '{0, bkvb_pkg::MODE_CLAMPED, 7, 48, 32'd30,        1, 0, 0, bkvb_pkg::ERR_NONE},
        '{1, bkvb_pkg::MODE_CLAMPED, 3, 2,  32'd42,        1, 1, 0, bkvb_pkg::ERR_FEW},
        '{1, bkvb_pkg::MODE_AVG,     1, 10, 32'd1,         0, 0, 0, bkvb_pkg::ERR_NONE},
        '{0, bkvb_pkg::MODE_AVG,     1, 10, 32'd2,         0, 0, 0, bkvb_pkg::ERR_NONE},
        '{0, bkvb_pkg::MODE_AVG,     1, 10, 32'd4,         0, 0, 0, bkvb_pkg::ERR_NONE},
        '{0, bkvb_pkg::MODE_AVG,     1, 10, 32'd3,         1, 0, 0, bkvb_pkg::ERR_NONE}
    };

    initial
    begin
        int rand_items;
        int group;
        int nsets;
        int len;
        logic [31:0] base;
        logic [5:0] basis;
        logic [2:0] deg;
        rand_items = 0;
        group = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        foreach (plan[r])
        begin
            if (plan[r].cfg)
                setup_regs(plan[r].mode, plan[r].deg, plan[r].basis);
            send_sample(plan[r].sample, plan[r].lst, plan[r].typed, plan[r].t_knot,
                        plan[r].t_err);
        end
        while (rand_items < RAND_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0: deg = 3'd0;
                1: deg = 3'd7;
                default: deg = 3'($urandom_range(0, 7));
            endcase
            case ($urandom_range(0, 4))
                0: basis = 6'd0;
                1: basis = 6'd48;
                2: basis = 6'd63;
                default: basis = 6'($urandom_range(0, 20));
            endcase
            setup_regs(2'($urandom_range(0, 3)), deg, basis);
            nsets = (group == 1) ? 3 : $urandom_range(1, 4);
            for (int s = 0; s < nsets; s++)
            begin
                // hold the output off while later sets keep arriving
                if (group == 1 && s == 0)
                    hold_req = 1'b1;
                // fill the store past its depth once, then the odd time at random
                if ((group == 2 && s == 0) || $urandom_range(0, 40) == 0)
                begin
                    base = $urandom();
                    for (int i = 0; i < 52; i++)
                    begin
                        send_sample(base + 32'(i * 7), i == 51, 0, 0, bkvb_pkg::ERR_NONE);
                        rand_items++;
                    end
                end
                else
                begin
                    len = $urandom_range(1, 10);
                    for (int i = 0; i < len; i++)
                    begin
                        send_sample(rand_sample(), i == len - 1, 0, 0, bkvb_pkg::ERR_NONE);
                        rand_items++;
                    end
                end
            end
            group++;
        end
        drain();
        $display("ran %0d data sets, %0d samples; %0d knot beats checked across all modes",
                 sets_sent, samples_sent, knots_seen);
        if (fails == 0)
            $display("bspline_knot_vector_builder: match");
        else
            $display("bspline_knot_vector_builder: mismatch");
        $finish;
    end

    initial
    begin
        int seg_left;
        int pct;
        seg_left = 0;
        pct = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cnt > 0)
            begin
                out_stall <= 1'b1;
                hold_cnt--;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt = 2000;
                out_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(20, 200);
                    case ($urandom_range(0, 3))
                        0: pct = 0;
                        1: pct = 25;
                        2: pct = 50;
                        default: pct = 80;
                    endcase
                end
                seg_left--;
                out_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    always @(posedge clk)
    begin
        knot_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            knots_seen++;
            if (knot_q.size() == 0)
            begin
                $error("knot beat with nothing expected: knot_value %h", knot_value);
                fails++;
            end
            else
            begin
                want = knot_q.pop_front();
                if (knot_value !== want.knot)
                begin
                    $error("knot_value expected %h actual %h", want.knot, knot_value);
                    fails++;
                end
                if (error_code !== want.err)
                begin
                    $error("error_code expected %0d actual %0d", want.err, error_code);
                    fails++;
                end
                if (last_knot !== want.lst)
                begin
                    $error("last_knot expected %0d actual %0d", want.lst, last_knot);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("bspline_knot_vector_builder: mismatch");
            $finish;
        end
    end

endmodule
